/* src/imh_pkg.sv */
// Package for the indexed min-heap: widths, codes and sequencer states.
// No dependencies.
`default_nettype none
package imh_pkg;
   localparam int CapBits   = 8;
   localparam int CountBits = 9;
   localparam int KeyBits   = 32;
   localparam int VertBits  = 8;
   localparam logic [CountBits-1:0] Capacity = 9'd256;

   localparam logic [1:0] KIND_INSERT   = 2'd0;
   localparam logic [1:0] KIND_EXTRACT  = 2'd1;
   localparam logic [1:0] KIND_DECREASE = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_PRESENT = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_ABSENT  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_POS, S_LOAD, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_WAIT, S_DN_CMP, S_DONE
   } state_type;
endpackage
`default_nettype wire

/* src/imh_if.sv */
// Valid/ready channel interfaces for the min-heap.
// Depends on imh_pkg.
`default_nettype none
interface imh_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [imh_pkg::VertBits-1:0] vertex_id;
   logic signed [imh_pkg::KeyBits-1:0] new_key;
   modport source (output valid, kind, vertex_id, new_key, input ready);
   modport sink (input valid, kind, vertex_id, new_key, output ready);
endinterface

interface imh_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [imh_pkg::VertBits-1:0]  out_vertex;
   logic signed [imh_pkg::KeyBits-1:0] out_key;
   logic [2:0]                    status;
   logic [imh_pkg::CountBits-1:0] entry_count;
   logic                          heap_empty;
   modport source (output valid, out_vertex, out_key, status, entry_count, heap_empty,
                   input ready);
   modport sink (input valid, out_vertex, out_key, status, entry_count, heap_empty,
                 output ready);
endinterface
`default_nettype wire

/* src/imh_slot_mem.sv */
// Slot memory: vertex and key for each heap slot, two read and one write port.
// Depends on imh_pkg.
`default_nettype none
module imh_slot_mem (
   input  wire logic                         clock,
   input  wire logic [imh_pkg::CapBits-1:0]  rd_a_addr,
   input  wire logic [imh_pkg::CapBits-1:0]  rd_b_addr,
   output logic [imh_pkg::VertBits-1:0]      rd_a_vert,
   output logic [imh_pkg::KeyBits-1:0]       rd_a_key,
   output logic [imh_pkg::VertBits-1:0]      rd_b_vert,
   output logic [imh_pkg::KeyBits-1:0]       rd_b_key,
   input  wire logic                         wr_en,
   input  wire logic [imh_pkg::CapBits-1:0]  wr_addr,
   input  wire logic [imh_pkg::VertBits-1:0] wr_vert,
   input  wire logic [imh_pkg::KeyBits-1:0]  wr_key
);
   logic [imh_pkg::VertBits+imh_pkg::KeyBits-1:0] mem [2**imh_pkg::CapBits];

   // write one slot, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_vert, wr_key};
      end
      {rd_a_vert, rd_a_key} <= mem[rd_a_addr];
      {rd_b_vert, rd_b_key} <= mem[rd_b_addr];
   end
endmodule
`default_nettype wire

/* src/imh_pos_mem.sv */
// Position table: slot of each vertex, one read and one write port.
// Depends on imh_pkg.
`default_nettype none
module imh_pos_mem (
   input  wire logic                         clock,
   input  wire logic [imh_pkg::VertBits-1:0] rd_addr,
   output logic [imh_pkg::CapBits-1:0]       rd_slot,
   input  wire logic                         wr_en,
   input  wire logic [imh_pkg::VertBits-1:0] wr_addr,
   input  wire logic [imh_pkg::CapBits-1:0]  wr_slot
);
   logic [imh_pkg::CapBits-1:0] mem [2**imh_pkg::VertBits];

   // write one entry, read one
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_slot;
      end
      rd_slot <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/indexed_min_heap.sv */
// Top level of the indexed min-heap: sequencer over slot and position memories.
// Depends on imh_pkg, imh_if, imh_slot_mem, imh_pos_mem.
//
// Usage: requests arrive as words on req (insert, extract minimum, decrease
// key); each gives exactly one word on rsp with the removed vertex and key,
// a status code, the entry count and an empty flag. One request is worked at
// a time. The moving entry is held in registers and every sift level takes
// a parent read and a compare/write going up, and a child read, a read wait
// and a compare/write going down, bounded by the 9 levels of a 256-slot
// heap. Error, empty and unused-kind cases skip the sift and go straight to
// the result word. A new request is accepted only while the sequencer is
// idle and no result word waits.
// Synchronous reset clears the count, the presence map and the sequencer;
// memory contents are undefined until written and never read before that.
// The result word sits in an output register; while the receiver stalls it
// holds and no new request is taken.
`default_nettype none
module indexed_min_heap (
   input wire logic  clock,
   input wire logic  reset,
   imh_req_if.sink   req,
   imh_rsp_if.source rsp
);
   localparam int CB = imh_pkg::CapBits;
   localparam int KB = imh_pkg::KeyBits;
   localparam int VB = imh_pkg::VertBits;
   localparam int NB = imh_pkg::CountBits;

   imh_pkg::state_type state_ff, state_in;
   logic [NB-1:0] count_ff, count_in;
   logic [2**VB-1:0] present_ff;
   logic [CB-1:0] idx_ff, idx_in;
   logic [VB-1:0] vert_ff, vert_in;
   logic [KB-1:0] key_ff, key_in;
   logic [1:0] kind_ff;
   logic       up_moved_ff, up_moved_in;
   logic       rsp_valid_ff;
   logic [VB-1:0] out_vert_ff, out_vert_in;
   logic [KB-1:0] out_key_ff, out_key_in;
   logic [2:0] status_ff, status_in;

   logic [CB-1:0] rd_a_addr, rd_b_addr, wr_addr, pos_rd_addr;
   logic [VB-1:0] rd_a_vert, rd_b_vert, wr_vert, pos_wr_addr;
   logic [KB-1:0] rd_a_key, rd_b_key, wr_key;
   logic          wr_en, pos_wr_en;
   logic [CB-1:0] pos_rd_slot, pos_wr_slot;
   logic          accept;

   imh_slot_mem u_slot (
      .clock, .rd_a_addr, .rd_b_addr, .rd_a_vert, .rd_a_key,
      .rd_b_vert, .rd_b_key, .wr_en, .wr_addr, .wr_vert, .wr_key
   );
   imh_pos_mem u_pos (
      .clock, .rd_addr(pos_rd_addr[VB-1:0]), .rd_slot(pos_rd_slot),
      .wr_en(pos_wr_en), .wr_addr(pos_wr_addr), .wr_slot(pos_wr_slot)
   );

   assign req.ready = (state_ff == imh_pkg::S_IDLE) && !rsp_valid_ff;
   assign accept = req.valid && req.ready;

   // child and parent arithmetic
   logic [NB:0] lch, rch;
   logic [CB-1:0] parent;
   logic          l_in, r_in, l_less, r_less_l, r_less_cur, pick_l, pick_r;
   assign lch = {1'b0, idx_ff, 1'b1};
   assign rch = lch + 1'b1;
   assign parent = CB'((idx_ff - 1'b1) >> 1);
   assign l_in = (lch < (NB+1)'(count_ff));
   assign r_in = (rch < (NB+1)'(count_ff));
   assign l_less = $signed(rd_a_key) < $signed(key_ff);
   assign r_less_l = $signed(rd_b_key) < $signed(rd_a_key);
   assign r_less_cur = $signed(rd_b_key) < $signed(key_ff);
   assign pick_l = l_in && l_less && !(r_in && r_less_l);
   assign pick_r = r_in && (l_in && l_less ? r_less_l : r_less_cur);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imh_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req.kind)
                  imh_pkg::KIND_INSERT:
                     state_in = (count_ff >= imh_pkg::Capacity || present_ff[req.vertex_id])
                              ? imh_pkg::S_DONE : imh_pkg::S_UP_RD;
                  imh_pkg::KIND_EXTRACT:
                     state_in = (count_ff == '0) ? imh_pkg::S_DONE : imh_pkg::S_LOAD;
                  imh_pkg::KIND_DECREASE:
                     state_in = present_ff[req.vertex_id] ? imh_pkg::S_POS : imh_pkg::S_DONE;
                  default: state_in = imh_pkg::S_DONE;
               endcase
            end
         end
         imh_pkg::S_POS:  state_in = imh_pkg::S_UP_RD;
         imh_pkg::S_LOAD: state_in = imh_pkg::S_DN_RD;
         imh_pkg::S_UP_RD:
            state_in = (idx_ff == '0) ? imh_pkg::S_UP_CMP : imh_pkg::S_UP_CMP;
         imh_pkg::S_UP_CMP: begin
            if (idx_ff != '0 && $signed(key_ff) < $signed(rd_a_key)) begin
               state_in = imh_pkg::S_UP_RD;
            end else if (kind_ff == imh_pkg::KIND_DECREASE && !up_moved_ff) begin
               state_in = imh_pkg::S_DN_RD;
            end else begin
               state_in = imh_pkg::S_DONE;
            end
         end
         imh_pkg::S_DN_RD:   state_in = imh_pkg::S_DN_WAIT;
         imh_pkg::S_DN_WAIT: state_in = imh_pkg::S_DN_CMP;
         imh_pkg::S_DN_CMP:
            state_in = (pick_l || pick_r) ? imh_pkg::S_DN_RD : imh_pkg::S_DONE;
         imh_pkg::S_DONE: state_in = imh_pkg::S_IDLE;
         default: state_in = imh_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      idx_in = idx_ff;
      vert_in = vert_ff;
      key_in = key_ff;
      count_in = count_ff;
      up_moved_in = up_moved_ff;
      out_vert_in = out_vert_ff;
      out_key_in = out_key_ff;
      status_in = status_ff;
      rd_a_addr = parent;
      rd_b_addr = rch[CB-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_vert = vert_ff;
      wr_key = key_ff;
      pos_rd_addr = req.vertex_id;
      pos_wr_en = 1'b0;
      pos_wr_addr = vert_ff;
      pos_wr_slot = idx_ff;
      unique case (state_ff)
         imh_pkg::S_IDLE: begin
            rd_a_addr = '0;
            rd_b_addr = CB'(count_ff - 1'b1);
            if (accept) begin
               vert_in = req.vertex_id;
               key_in = req.new_key;
               up_moved_in = 1'b0;
               out_vert_in = '0;
               out_key_in = '0;
               status_in = imh_pkg::ST_OK;
               unique case (req.kind)
                  imh_pkg::KIND_INSERT: begin
                     if (count_ff >= imh_pkg::Capacity) begin
                        status_in = imh_pkg::ST_FULL;
                     end else if (present_ff[req.vertex_id]) begin
                        status_in = imh_pkg::ST_PRESENT;
                     end else begin
                        idx_in = count_ff[CB-1:0];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  imh_pkg::KIND_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = imh_pkg::ST_EMPTY;
                     end else begin
                        idx_in = '0;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  imh_pkg::KIND_DECREASE: begin
                     if (!present_ff[req.vertex_id]) status_in = imh_pkg::ST_ABSENT;
                  end
                  default: ;
               endcase
            end
         end
         imh_pkg::S_POS: begin
            idx_in = (NB'(pos_rd_slot) >= count_ff) ? '0 : pos_rd_slot;
         end
         imh_pkg::S_LOAD: begin
            // root and last slot have been read; hold last entry as mover
            out_vert_in = rd_a_vert;
            out_key_in = rd_a_key;
            vert_in = rd_b_vert;
            key_in = rd_b_key;
            if (count_ff == '0) begin
               vert_in = rd_a_vert;
            end
         end
         imh_pkg::S_UP_RD: rd_a_addr = parent;
         imh_pkg::S_UP_CMP: begin
            if (idx_ff != '0 && $signed(key_ff) < $signed(rd_a_key)) begin
               // move parent down into this slot
               wr_en = 1'b1;
               wr_vert = rd_a_vert;
               wr_key = rd_a_key;
               pos_wr_en = 1'b1;
               pos_wr_addr = rd_a_vert;
               idx_in = parent;
               up_moved_in = 1'b1;
            end else if (!(kind_ff == imh_pkg::KIND_DECREASE && !up_moved_ff)) begin
               wr_en = 1'b1;
               pos_wr_en = 1'b1;
            end
         end
         imh_pkg::S_DN_RD: begin
            rd_a_addr = lch[CB-1:0];
            rd_b_addr = rch[CB-1:0];
         end
         imh_pkg::S_DN_WAIT: begin
            rd_a_addr = lch[CB-1:0];
            rd_b_addr = rch[CB-1:0];
         end
         imh_pkg::S_DN_CMP: begin
            wr_en = 1'b1;
            pos_wr_en = 1'b1;
            if (pick_l) begin
               wr_vert = rd_a_vert;
               wr_key = rd_a_key;
               pos_wr_addr = rd_a_vert;
               idx_in = lch[CB-1:0];
            end else if (pick_r) begin
               wr_vert = rd_b_vert;
               wr_key = rd_b_key;
               pos_wr_addr = rd_b_vert;
               idx_in = rch[CB-1:0];
            end
         end
         imh_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imh_pkg::S_IDLE;
         count_ff <= '0;
         present_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (accept && req.kind == imh_pkg::KIND_INSERT && status_in == imh_pkg::ST_OK) begin
            present_ff[req.vertex_id] <= 1'b1;
         end
         if (state_ff == imh_pkg::S_LOAD) begin
            present_ff[rd_a_vert] <= 1'b0;
         end
         if (state_ff == imh_pkg::S_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      vert_ff <= vert_in;
      key_ff <= key_in;
      up_moved_ff <= up_moved_in;
      out_vert_ff <= out_vert_in;
      out_key_ff <= out_key_in;
      status_ff <= status_in;
      if (accept) kind_ff <= req.kind;
   end

   // when the extract empties the heap it still passes the sift-down states: no child is in range
   // (mover write at slot 0 is harmless since slot 0 is beyond count)

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_vertex = out_vert_ff;
   assign rsp.out_key = out_key_ff;
   assign rsp.status = status_ff;
   assign rsp.entry_count = count_ff;
   assign rsp.heap_empty = (count_ff == '0);

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= imh_pkg::Capacity) else $error("count exceeds capacity");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("request taken while result waits");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff)) else $error("count changed without request");
endmodule
`default_nettype wire

/* bench/indexed_min_heap_tb.sv */
// Testbench for indexed_min_heap: drives insert, extract, decrease and unused-kind words and
// checks every response against a heap predictor held in a scoreboard class.
// Depends on imh_pkg, imh_if and the indexed_min_heap RTL.
`timescale 1ns / 1ps
module indexed_min_heap_tb;

   typedef struct packed {
      logic [imh_pkg::VertBits-1:0]       vertex;
      logic signed [imh_pkg::KeyBits-1:0] key;
      logic [2:0]                         status;
      logic [imh_pkg::CountBits-1:0]      count;
      logic                               empty;
   } heap_word_type;

   // Heap predictor and store of expected response words
   class heap_scoreboard;
      logic [imh_pkg::VertBits-1:0]       slot_vert [256];
      logic signed [imh_pkg::KeyBits-1:0] slot_key [256];
      int                                 vert_slot [256];
      bit                                 held [256];
      int                                 entries;
      heap_word_type                      pending_words [$];

      function new();
         entries = 0;
         foreach (held[i]) held[i] = 0;
      endfunction

      function void swap(int a, int b);
         logic [imh_pkg::VertBits-1:0]       tv;
         logic signed [imh_pkg::KeyBits-1:0] tk;
         tv = slot_vert[a]; tk = slot_key[a];
         slot_vert[a] = slot_vert[b]; slot_key[a] = slot_key[b];
         slot_vert[b] = tv; slot_key[b] = tk;
         vert_slot[slot_vert[a]] = a;
         vert_slot[slot_vert[b]] = b;
      endfunction

      function int rise(int i);
         int p;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!(slot_key[i] < slot_key[p])) break;
            swap(i, p);
            i = p;
         end
         return i;
      endfunction

      function void sink(int i);
         int l, r, s;
         forever begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            s = i;
            if (l < entries && slot_key[l] < slot_key[s]) s = l;
            if (r < entries && slot_key[r] < slot_key[s]) s = r;
            if (s == i) break;
            swap(i, s);
            i = s;
         end
      endfunction

      // Note an accepted request word and queue its expected response
      function void note_request(logic [1:0] kind, logic [imh_pkg::VertBits-1:0] v,
                                 logic signed [imh_pkg::KeyBits-1:0] key);
         heap_word_type w;
         int            i;
         w = '0;
         w.status = imh_pkg::ST_OK;
         if (kind == imh_pkg::KIND_INSERT) begin
            if (entries >= 256) w.status = imh_pkg::ST_FULL;
            else if (held[v]) w.status = imh_pkg::ST_PRESENT;
            else begin
               i = entries;
               slot_vert[i] = v; slot_key[i] = key;
               vert_slot[v] = i; held[v] = 1;
               entries++;
               void'(rise(i));
            end
         end else if (kind == imh_pkg::KIND_EXTRACT) begin
            if (entries == 0) w.status = imh_pkg::ST_EMPTY;
            else begin
               w.vertex = slot_vert[0];
               w.key = slot_key[0];
               held[slot_vert[0]] = 0;
               entries--;
               if (entries > 0) begin
                  slot_vert[0] = slot_vert[entries];
                  slot_key[0] = slot_key[entries];
                  vert_slot[slot_vert[0]] = 0;
                  sink(0);
               end
            end
         end else if (kind == imh_pkg::KIND_DECREASE) begin
            if (!held[v]) w.status = imh_pkg::ST_ABSENT;
            else begin
               i = vert_slot[v];
               slot_key[i] = key;
               if (rise(i) == i) sink(i);
            end
         end
         w.count = entries[imh_pkg::CountBits-1:0];
         w.empty = (entries == 0);
         pending_words.push_back(w);
      endfunction

      // Compare a response word with the oldest expectation; empty string on match
      function string check_response(heap_word_type got);
         heap_word_type e;
         if (pending_words.size() == 0) return "response with nothing expected";
         e = pending_words.pop_front();
         if (got !== e)
            return $sformatf("got v=%0d k=%0d st=%0d n=%0d e=%0b, want v=%0d k=%0d st=%0d n=%0d e=%0b",
                             got.vertex, got.key, got.status, got.count, got.empty,
                             e.vertex, e.key, e.status, e.count, e.empty);
         return "";
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   quiet = 0;
   int   errors = 0;
   heap_scoreboard sb = new();

   imh_req_if req ();
   imh_rsp_if rsp ();

   indexed_min_heap u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #5 clock = ~clock;

   initial begin
      req.valid = 0; req.kind = imh_pkg::KIND_INSERT; req.vertex_id = '0; req.new_key = '0;
      rsp.ready = 0;
   end

   task automatic report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   // Receiver: stall in random bursts unless quiet, check each accepted response word
   int stall_left = 0;
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp.valid && rsp.ready) begin
         msg = sb.check_response({rsp.out_vertex, rsp.out_key, rsp.status,
                                  rsp.entry_count, rsp.heap_empty});
         if (msg != "") report(msg);
      end
      if (reset) rsp.ready <= 0;
      else if (quiet) rsp.ready <= 1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp.ready <= 0;
      end else rsp.ready <= 1;
   end

   // Send one request word, with an occasional idle burst in front unless quiet
   task automatic send(logic [1:0] kind, logic [imh_pkg::VertBits-1:0] v,
                       logic signed [imh_pkg::KeyBits-1:0] key);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req.valid <= 1;
      req.kind <= kind;
      req.vertex_id <= v;
      req.new_key <= key;
      do @(posedge clock); while (!req.ready);
      sb.note_request(kind, v, key);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Pick a vertex, mostly one whose held flag matches want_held
   function automatic logic [imh_pkg::VertBits-1:0] pick_vertex(bit want_held);
      int tries;
      logic [imh_pkg::VertBits-1:0] v;
      for (tries = 0; tries < 16; tries++) begin
         v = $urandom_range(0, 255);
         if (sb.held[v] == want_held) return v;
      end
      return v;
   endfunction

   initial begin
      int n, r;
      logic [1:0] kind;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty and absent cases, key extremes, ties, duplicates, an unused kind
      send(imh_pkg::KIND_EXTRACT, 8'd0, 0);
      send(imh_pkg::KIND_DECREASE, 8'd7, 5);
      send(imh_pkg::KIND_INSERT, 8'd0, 32'sh7FFFFFFF);
      send(imh_pkg::KIND_INSERT, 8'd255, 32'sh80000000);
      send(imh_pkg::KIND_INSERT, 8'd0, 1);
      send(2'd3, 8'd9, -1);
      send(imh_pkg::KIND_INSERT, 8'd10, 100);
      send(imh_pkg::KIND_INSERT, 8'd11, 100);
      send(imh_pkg::KIND_INSERT, 8'd12, 100);
      send(imh_pkg::KIND_DECREASE, 8'd255, 32'sh7FFFFFFF);   // larger key sinks
      send(imh_pkg::KIND_DECREASE, 8'd0, 32'sh80000000);
      send(imh_pkg::KIND_DECREASE, 8'd12, 100);
      send(imh_pkg::KIND_DECREASE, 8'd11, -5);
      repeat (7) send(imh_pkg::KIND_EXTRACT, 8'hAA, 0);
      drain();

      // Fill every slot, then overflow, decrease one key, drain, then empty the heap and extract once more
      for (n = 0; n < 256; n++)
         send(imh_pkg::KIND_INSERT, n[7:0], $urandom_range(0, 15) - 8);
      send(imh_pkg::KIND_INSERT, 8'd3, 0);
      send(imh_pkg::KIND_DECREASE, 8'd200, 32'sh80000000);
      drain();
      repeat (256) send(imh_pkg::KIND_EXTRACT, 8'd0, $urandom);
      send(imh_pkg::KIND_EXTRACT, 8'd0, 0);

      // Random mix, mostly well-formed operations
      for (n = 0; n < 250; n++) begin
         if (n == 200) quiet = 1;
         r = $urandom_range(0, 99);
         if (r < 45) kind = imh_pkg::KIND_INSERT;
         else if (r < 72) kind = imh_pkg::KIND_EXTRACT;
         else if (r < 96) kind = imh_pkg::KIND_DECREASE;
         else kind = 2'd3;
         if (n == 120) drain();
         send(kind, pick_vertex(kind != imh_pkg::KIND_INSERT || r < 3),
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63) - 32);
      end
      while (sb.entries > 0) send(imh_pkg::KIND_EXTRACT, 8'd0, 0);
      drain();

      if (errors == 0) $display("indexed_min_heap: match");
      else $display("indexed_min_heap: mismatch");
      $finish;
   end

   initial begin
      #20ms;
      $display("indexed_min_heap: mismatch");
      $finish;
   end
endmodule
